/* hw/rtl/ptuv_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the planar
// texture projection block. No dependencies.
`timescale 1ns / 1ps

package ptuv_pkg;

    localparam int OUT_FRAC_BITS_DEF = 16;

    // Dot product of a Q24.8 point with Q.16 rotated axes.
    localparam int DOT_W = 51;
    // Magnitude of dot * 256 fed to the scale divider.
    localparam int Q1_W  = 58;
    // Scaled dot plus offset, signed.
    localparam int SUM_W = 60;

    localparam int CORDIC_ITERS = 16;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [16:0] ROT_FULL = 17'd36000;
    localparam logic [16:0] ROT_Q1   = 17'd9000;
    localparam logic [16:0] ROT_Q2   = 17'd18000;
    localparam logic [16:0] ROT_Q3   = 17'd27000;

    localparam logic signed [17:0] TRIG_ONE = 18'sd65536;
    localparam logic signed [15:0] SCALE_ONE = 16'sd256;

    localparam logic [2:0] CFG_ROTATION = 3'd0;
    localparam logic [2:0] CFG_SCALE_S  = 3'd1;
    localparam logic [2:0] CFG_SCALE_T  = 3'd2;
    localparam logic [2:0] CFG_OFFSET_S = 3'd3;
    localparam logic [2:0] CFG_OFFSET_T = 3'd4;
    localparam logic [2:0] CFG_WIDTH    = 3'd5;
    localparam logic [2:0] CFG_HEIGHT   = 3'd6;

    typedef struct packed {
        logic signed [17:0] sn;
        logic signed [17:0] cs;
    } sincos_t;

    // Arctangent of 2^-i in units of 1/25600 degree.
    function automatic logic [20:0] atan_lut(input logic [3:0] i);
        logic [20:0] r;
        unique case (i)
            4'd0:  r = 21'd1152000;
            4'd1:  r = 21'd680065;
            4'd2:  r = 21'd359328;
            4'd3:  r = 21'd182400;
            4'd4:  r = 21'd91554;
            4'd5:  r = 21'd45822;
            4'd6:  r = 21'd22916;
            4'd7:  r = 21'd11459;
            4'd8:  r = 21'd5730;
            4'd9:  r = 21'd2865;
            4'd10: r = 21'd1432;
            4'd11: r = 21'd716;
            4'd12: r = 21'd358;
            4'd13: r = 21'd179;
            4'd14: r = 21'd90;
            default: r = 21'd45;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/ptuv_cordic.sv */
// Iterative sine/cosine unit run once per rotation register write.
// Depends on ptuv_pkg.
`timescale 1ns / 1ps

module ptuv_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [15:0]       rot,
    output logic              busy,
    output ptuv_pkg::sincos_t sc
);
    import ptuv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ITER   = 3'b010,
        ST_FINISH = 3'b100
    } cstate_t;

    cstate_t            state_reg, state_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [25:0] z_reg, z_next;
    logic [3:0]         iter_reg, iter_next;
    logic [1:0]         quad_reg, quad_next;
    sincos_t            sc_reg, sc_next;

    logic [16:0] r_wrap, resid;
    logic [1:0]  quad_in;

    function automatic logic signed [17:0] rnd14(input logic signed [33:0] v);
        logic signed [33:0] t;
        if (v >= 0)
            t = (v + 34'sd8192) >>> 14;
        else
            t = -((-v + 34'sd8192) >>> 14);
        return t[17:0];
    endfunction

    function automatic sincos_t quad_map(input logic [1:0] q,
                                         input logic signed [17:0] sa,
                                         input logic signed [17:0] ca);
        sincos_t r;
        case (q)
            2'd0:    begin r.sn = sa;  r.cs = ca;  end
            2'd1:    begin r.sn = ca;  r.cs = -sa; end
            2'd2:    begin r.sn = -sa; r.cs = -ca; end
            default: begin r.sn = -ca; r.cs = sa;  end
        endcase
        return r;
    endfunction

    always_comb
    begin
        r_wrap = ({1'b0, rot} >= ROT_FULL) ? ({1'b0, rot} - ROT_FULL) : {1'b0, rot};
        if (r_wrap >= ROT_Q3)
        begin
            quad_in = 2'd3;
            resid   = r_wrap - ROT_Q3;
        end
        else if (r_wrap >= ROT_Q2)
        begin
            quad_in = 2'd2;
            resid   = r_wrap - ROT_Q2;
        end
        else if (r_wrap >= ROT_Q1)
        begin
            quad_in = 2'd1;
            resid   = r_wrap - ROT_Q1;
        end
        else
        begin
            quad_in = 2'd0;
            resid   = r_wrap;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        iter_next  = iter_reg;
        quad_next  = quad_reg;
        sc_next    = sc_reg;
        if (load)
        begin
            quad_next = quad_in;
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = $signed({1'b0, resid[16:0], 8'd0});
            iter_next = '0;
            if (resid == '0)
            begin
                // Whole quadrants need no iteration and come out exact.
                sc_next    = quad_map(quad_in, 18'sd0, TRIG_ONE);
                state_next = ST_IDLE;
            end
            else
                state_next = ST_ITER;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_ITER:
                begin
                    if (z_reg >= 0)
                    begin
                        x_next = x_reg - (y_reg >>> iter_reg);
                        y_next = y_reg + (x_reg >>> iter_reg);
                        z_next = z_reg - $signed({5'd0, atan_lut(iter_reg)});
                    end
                    else
                    begin
                        x_next = x_reg + (y_reg >>> iter_reg);
                        y_next = y_reg - (x_reg >>> iter_reg);
                        z_next = z_reg + $signed({5'd0, atan_lut(iter_reg)});
                    end
                    iter_next = iter_reg + 4'd1;
                    if (iter_reg == 4'(CORDIC_ITERS - 1))
                        state_next = ST_FINISH;
                end
                ST_FINISH:
                begin
                    sc_next    = quad_map(quad_reg, rnd14(y_reg), rnd14(x_reg));
                    state_next = ST_IDLE;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            quad_reg  <= '0;
            sc_reg.sn <= '0;
            sc_reg.cs <= TRIG_ONE;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            quad_reg  <= quad_next;
            sc_reg    <= sc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign sc   = sc_reg;

endmodule

/* hw/rtl/ptuv_div.sv */
// Pipelined restoring divider, one quotient bit per stage, sign carried alongside.
// The divisor must hold while items are in flight. No package dependency.
`timescale 1ns / 1ps

module ptuv_div #(
    parameter int NB = 58,
    parameter int DB = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NB-1:0] in_dividend,
    input  logic          in_neg,
    input  logic [DB-1:0] divisor,
    output logic          out_valid,
    output logic [NB-1:0] out_quot,
    output logic          out_neg
);

    logic [NB-1:0] w_reg [NB];
    logic [DB-1:0] r_reg [NB];
    logic          v_reg [NB];
    logic          n_reg [NB];

    for (genvar s = 0; s < NB; s++)
    begin : g_stage
        logic [NB-1:0] w_prev, w_next;
        logic [DB-1:0] r_prev, r_next;
        logic          v_prev, n_prev;
        logic [DB:0]   trial, diff;
        logic          ge;

        if (s == 0)
        begin : g_first
            assign w_prev = in_dividend;
            assign r_prev = '0;
            assign v_prev = in_valid;
            assign n_prev = in_neg;
        end
        else
        begin : g_rest
            assign w_prev = w_reg[s-1];
            assign r_prev = r_reg[s-1];
            assign v_prev = v_reg[s-1];
            assign n_prev = n_reg[s-1];
        end

        // The dividend shifts out at the top while quotient bits shift in below.
        always_comb
        begin
            trial  = {r_prev, w_prev[NB-1]};
            diff   = trial - {1'b0, divisor};
            ge     = (trial >= {1'b0, divisor});
            r_next = ge ? diff[DB-1:0] : trial[DB-1:0];
            w_next = {w_prev[NB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else
                v_reg[s] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            w_reg[s] <= w_next;
            r_reg[s] <= r_next;
            n_reg[s] <= n_prev;
        end
    end

    assign out_valid = v_reg[NB-1];
    assign out_quot  = w_reg[NB-1];
    assign out_neg   = n_reg[NB-1];

endmodule

/* hw/rtl/ptuv_front.sv */
// Axis selection, rotated-axis multiplies and dot products, three stages.
// Depends on ptuv_pkg.
`timescale 1ns / 1ps

module ptuv_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    input  logic signed [31:0]               point_z,
    input  logic signed [15:0]               normal_x,
    input  logic signed [15:0]               normal_y,
    input  logic signed [15:0]               normal_z,
    input  ptuv_pkg::sincos_t                sc,
    output logic                             out_valid,
    output logic signed [ptuv_pkg::DOT_W-1:0] dot_s,
    output logic signed [ptuv_pkg::DOT_W-1:0] dot_t
);
    import ptuv_pkg::*;

    logic signed [16:0] dots [6];
    logic signed [16:0] best;
    logic [2:0]         best_idx;
    logic signed [31:0] ps_next, pt_next, ps_reg, pt_reg;
    logic signed [49:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [DOT_W-1:0] ds_reg, dt_reg;
    logic a_valid_reg, b_valid_reg, c_valid_reg;

    always_comb
    begin
        dots[0] = 17'(normal_z);
        dots[1] = -17'(normal_z);
        dots[2] = 17'(normal_x);
        dots[3] = -17'(normal_x);
        dots[4] = 17'(normal_y);
        dots[5] = -17'(normal_y);
        best     = '0;
        best_idx = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (dots[i] > best)
            begin
                best     = dots[i];
                best_idx = 3'(i);
            end
        end
        // Z faces project on (x, y), X faces on (y, z), Y faces on (x, z).
        case (best_idx)
            3'd0, 3'd1: begin ps_next = point_x; pt_next = point_y; end
            3'd2, 3'd3: begin ps_next = point_y; pt_next = point_z; end
            default:    begin ps_next = point_x; pt_next = point_z; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ps_reg <= ps_next;
        pt_reg <= pt_next;
        m0_reg <= ps_reg * $signed(sc.cs);
        m1_reg <= pt_reg * $signed(sc.sn);
        m2_reg <= ps_reg * $signed(sc.sn);
        m3_reg <= pt_reg * $signed(sc.cs);
        ds_reg <= DOT_W'(m0_reg) + DOT_W'(m1_reg);
        dt_reg <= DOT_W'(m2_reg) - DOT_W'(m3_reg);
    end

    assign out_valid = c_valid_reg;
    assign dot_s     = ds_reg;
    assign dot_t     = dt_reg;

endmodule

/* hw/rtl/ptuv_chan.sv */
// One texture axis: divide by scale, add offset, divide by texture size.
// Depends on ptuv_pkg and ptuv_div.
`timescale 1ns / 1ps

module ptuv_chan #(
    parameter int OUT_FRAC_BITS = ptuv_pkg::OUT_FRAC_BITS_DEF,
    localparam int Q2_W = ptuv_pkg::SUM_W - 1 - (24 - OUT_FRAC_BITS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [ptuv_pkg::DOT_W-1:0] dot,
    input  logic signed [15:0]                scale,
    input  logic signed [15:0]                offset,
    input  logic [12:0]                       size,
    output logic                              out_valid,
    output logic signed [Q2_W:0]              quot
);
    import ptuv_pkg::*;

    localparam int SHIFT = 24 - OUT_FRAC_BITS;

    logic signed [15:0]  sc_eff;
    logic [15:0]         sc_mag;
    logic [12:0]         size_eff;
    logic signed [DOT_W-1:0] dot_abs;

    logic                p_valid_reg, p_neg_reg;
    logic [Q1_W-1:0]     p_mag_reg;
    logic                d1_valid, d1_neg;
    logic [Q1_W-1:0]     d1_quot;
    logic signed [Q1_W:0] q1s;
    logic                f_valid_reg;
    logic signed [SUM_W-1:0] f_sum_reg, f_sum_next, f_abs;
    logic                g_valid_reg, g_neg_reg;
    logic [Q2_W-1:0]     g_mag_reg;
    logic                d2_valid, d2_neg;
    logic [Q2_W-1:0]     d2_quot;

    always_comb
    begin
        sc_eff   = (scale == '0) ? SCALE_ONE : scale;
        sc_mag   = sc_eff[15] ? 16'(-sc_eff) : 16'(sc_eff);
        size_eff = (size == '0) ? 13'd1 : size;
        dot_abs  = dot[DOT_W-1] ? -dot : dot;
        q1s      = d1_neg ? -$signed({1'b0, d1_quot}) : $signed({1'b0, d1_quot});
        f_sum_next = SUM_W'(q1s) + $signed({{(SUM_W-40){offset[15]}}, offset, 24'd0});
        f_abs    = f_sum_reg[SUM_W-1] ? -f_sum_reg : f_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            f_valid_reg <= d1_valid;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_mag_reg <= {dot_abs[DOT_W-2:0], 8'd0};
        p_neg_reg <= dot[DOT_W-1] ^ sc_eff[15];
        f_sum_reg <= f_sum_next;
        // Dividing by size * 2^SHIFT is the same as a shift then a divide by size.
        g_mag_reg <= f_abs[SUM_W-2:SHIFT];
        g_neg_reg <= f_sum_reg[SUM_W-1];
    end

    ptuv_div #(.NB(Q1_W), .DB(16)) u_div_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (p_valid_reg),
        .in_dividend (p_mag_reg),
        .in_neg      (p_neg_reg),
        .divisor     (sc_mag),
        .out_valid   (d1_valid),
        .out_quot    (d1_quot),
        .out_neg     (d1_neg)
    );

    ptuv_div #(.NB(Q2_W), .DB(13)) u_div_size (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (g_valid_reg),
        .in_dividend (g_mag_reg),
        .in_neg      (g_neg_reg),
        .divisor     (size_eff),
        .out_valid   (d2_valid),
        .out_quot    (d2_quot),
        .out_neg     (d2_neg)
    );

    assign out_valid = d2_valid;
    assign quot = d2_neg ? -$signed({1'b0, d2_quot}) : $signed({1'b0, d2_quot});

endmodule

/* hw/rtl/planar_texture_uv_projection.sv */
// Top level of the planar texture projection block: configuration registers,
// front end, two axis channels and output saturation. Depends on all ptuv_ modules.
`timescale 1ns / 1ps

// One vertex is taken per clock whenever busy is low, and each gives one (U, V)
// beat on tex_u and tex_v, marked by done for a single cycle. Each vertex
// passes through the front end, the scale divider, the offset and shift registers,
// the size divider and the output register before done rises; the two bit-serial
// divider pipelines make up most of that path. The receiver cannot stall, so
// results are never held.
// A write to the rotation register starts the sine/cosine unit, and busy stays
// high while it iterates; for whole quadrants it does not rise.
module planar_texture_uv_projection #(
    parameter int OUT_FRAC_BITS = ptuv_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    output logic               done,
    output logic signed [31:0] tex_u,
    output logic signed [31:0] tex_v,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import ptuv_pkg::*;

    localparam int Q2_W = SUM_W - 1 - (24 - OUT_FRAC_BITS);

    logic signed [15:0] scale_s_reg, scale_t_reg, offset_s_reg, offset_t_reg;
    logic [12:0]        width_reg, height_reg;
    logic               cfg_we, rot_load, cordic_busy;
    sincos_t            sc;

    logic                    f_valid;
    logic signed [DOT_W-1:0] dot_s, dot_t;
    logic                    u_valid, v_valid;
    logic signed [Q2_W:0]    q_u, q_v, v_neg;
    logic                    done_reg;
    logic signed [31:0]      tex_u_reg, tex_v_reg;

    function automatic logic signed [31:0] sat32(input logic signed [Q2_W:0] v);
        logic signed [31:0] r;
        if (v[Q2_W:31] == '0 || v[Q2_W:31] == '1)
            r = v[31:0];
        else if (v[Q2_W])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign rot_load  = cfg_we && (cfg_index == CFG_ROTATION);
    assign busy      = cordic_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_s_reg  <= SCALE_ONE;
            scale_t_reg  <= SCALE_ONE;
            offset_s_reg <= '0;
            offset_t_reg <= '0;
            width_reg    <= 13'd64;
            height_reg   <= 13'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROTATION: ;
                CFG_SCALE_S:  scale_s_reg  <= cfg_data;
                CFG_SCALE_T:  scale_t_reg  <= cfg_data;
                CFG_OFFSET_S: offset_s_reg <= cfg_data;
                CFG_OFFSET_T: offset_t_reg <= cfg_data;
                CFG_WIDTH:    width_reg    <= cfg_data[12:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    ptuv_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (rot_load),
        .rot   (cfg_data),
        .busy  (cordic_busy),
        .sc    (sc)
    );

    ptuv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .sc        (sc),
        .out_valid (f_valid),
        .dot_s     (dot_s),
        .dot_t     (dot_t)
    );

    ptuv_chan #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_chan_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dot       (dot_s),
        .scale     (scale_s_reg),
        .offset    (offset_s_reg),
        .size      (width_reg),
        .out_valid (u_valid),
        .quot      (q_u)
    );

    ptuv_chan #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_chan_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dot       (dot_t),
        .scale     (scale_t_reg),
        .offset    (offset_t_reg),
        .size      (height_reg),
        .out_valid (v_valid),
        .quot      (q_v)
    );

    // V runs downwards in texture space, so its quotient is negated first.
    assign v_neg = -q_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= u_valid && v_valid;
    end

    always_ff @(posedge clk)
    begin
        tex_u_reg <= sat32(q_u);
        tex_v_reg <= sat32(v_neg);
    end

    assign done  = done_reg;
    assign tex_u = tex_u_reg;
    assign tex_v = tex_v_reg;

endmodule
